### sv/tea_pkg.sv
// Shared types and constants for the top error address table.
`timescale 1ns / 1ps

package tea_pkg;

	localparam int Entries = 8;
	localparam int PtrW    = (Entries > 1) ? $clog2(Entries) : 1;

	localparam logic [PtrW-1:0] LastPtr   = PtrW'(Entries - 1);
	localparam logic [7:0]      NoAddress = 8'hFF;
	localparam logic [31:0]     CountMax  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0]  addr;
		logic [31:0] count;
		logic [47:0] stamp;
	} entry_t;

	// ordering key: count first, then time
	typedef struct packed {
		logic [31:0] count;
		logic [47:0] stamp;
	} key_t;

	typedef struct packed {
		logic            move_en;
		logic [PtrW-1:0] src;
		logic [PtrW-1:0] dst;
		entry_t          wdata;
	} tbl_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RANK,
		ST_MOVE,
		ST_OUT
	} state_t;

endpackage

### sv/tea_cmp.sv
// Shared magnitude compare unit for table keys.
`timescale 1ns / 1ps

module tea_cmp
	import tea_pkg::*;
(
	input  key_t key_a,
	input  key_t key_b,
	output logic a_gt,
	output logic a_eq
);

	assign a_gt = key_a > key_b;
	assign a_eq = key_a == key_b;

endmodule

### sv/tea_table.sv
// Slot register array with one read port and a reposition move.
`timescale 1ns / 1ps

module tea_table
	import tea_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [PtrW-1:0] rd_ptr,
	output entry_t          rd_entry,
	input  tbl_ctrl_t       ctrl
);

	entry_t slot_q [Entries];

	assign rd_entry = slot_q[rd_ptr];

	for (genvar k = 0; k < Entries; k++) begin : g_slot
		entry_t          from_below;
		entry_t          from_above;
		logic [PtrW-1:0] kp;

		assign kp = PtrW'(k);

		if (k < Entries - 1) begin : g_below
			assign from_below = slot_q[k+1];
		end else begin : g_last
			assign from_below = slot_q[k];
		end

		if (k > 0) begin : g_above
			assign from_above = slot_q[k-1];
		end else begin : g_first
			assign from_above = slot_q[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				slot_q[k] <= '0;
			end else if (ctrl.move_en) begin
				if (kp == ctrl.dst) begin
					slot_q[k] <= ctrl.wdata;
				end else if (ctrl.src < ctrl.dst && kp >= ctrl.src && kp < ctrl.dst) begin
					// entry moves down the ranks: close the gap from below
					slot_q[k] <= from_below;
				end else if (ctrl.dst < ctrl.src && kp > ctrl.dst && kp <= ctrl.src) begin
					slot_q[k] <= from_above;
				end
			end
		end
	end

endmodule

### sv/top_error_address_table.sv
// Top level: sequencer and datapath of the top error address table.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | input     | in_valid/in_ready  | mode, address, index, event_time
//  out     | output    | out_valid/out_ready| entry_address, entry_count, entry_last_seen,
//          |           |                    | entry_used, entry_rank, latest_error_address
//
// A record transaction makes one pass of the shared key comparator over the slots to find the
// match or the least count and a second pass to find the new rank, then moves the entry and
// loads the result once the output register is free. A read transaction goes from idle
// straight to loading the result. in_ready is high only when the sequencer is idle.
// Reset clears all slots to zero and the latest address to 0xFF at once.
// A stalled result holds in the output register while the next transaction is accepted.
`timescale 1ns / 1ps

module top_error_address_table
	import tea_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  address,
	input  logic [2:0]  index,
	input  logic [47:0] event_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  entry_address,
	output logic [31:0] entry_count,
	output logic [47:0] entry_last_seen,
	output logic        entry_used,
	output logic [2:0]  entry_rank,
	output logic [7:0]  latest_error_address
);

	state_t          state_q, state_d;
	logic [PtrW-1:0] ptr_q;
	logic [PtrW-1:0] least_q;
	logic [31:0]     least_cnt_q;
	logic [PtrW-1:0] p_q;
	logic [PtrW-1:0] q_q;
	logic [7:0]      addr_q;
	logic [47:0]     time_q;
	entry_t          upd_q;
	logic [2:0]      rank_q;
	logic            oor_q;
	logic [7:0]      newest_q;
	logic            out_valid_q;

	entry_t    rd_entry;
	tbl_ctrl_t tbl_ctrl;
	key_t      key_a, key_b;
	logic      a_gt, a_eq;
	logic      load_out;
	logic      addr_hit;
	logic      last;
	logic      take_least;
	logic [31:0] bumped;

	tea_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_ptr   (ptr_q),
		.rd_entry (rd_entry),
		.ctrl     (tbl_ctrl)
	);

	tea_cmp u_cmp (
		.key_a (key_a),
		.key_b (key_b),
		.a_gt  (a_gt),
		.a_eq  (a_eq)
	);

	assign addr_hit   = rd_entry.addr == addr_q;
	assign last       = ptr_q == LastPtr;
	assign take_least = (ptr_q == '0) || a_gt;
	assign bumped     = (rd_entry.count == CountMax) ? rd_entry.count : rd_entry.count + 32'd1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = mode ? ST_OUT : ST_SCAN;
			end
			ST_SCAN: begin
				if (addr_hit || last) state_d = ST_RANK;
			end
			ST_RANK: begin
				if (last) state_d = ST_MOVE;
			end
			ST_MOVE: state_d = ST_OUT;
			ST_OUT: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		tbl_ctrl = '{move_en: 1'b0, src: p_q, dst: q_q, wdata: upd_q};
		key_a    = '{count: least_cnt_q, stamp: '0};
		key_b    = '{count: rd_entry.count, stamp: '0};
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: ;
			ST_RANK: begin
				key_a = '{count: rd_entry.count, stamp: rd_entry.stamp};
				key_b = '{count: upd_q.count, stamp: upd_q.stamp};
			end
			ST_MOVE: tbl_ctrl.move_en = 1'b1;
			ST_OUT:  load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			newest_q    <= NoAddress;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (mode) begin
							oor_q  <= !(32'(index) < 32'(Entries));
							ptr_q  <= PtrW'(index);
							rank_q <= index;
						end else begin
							addr_q <= address;
							time_q <= event_time;
							ptr_q  <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (addr_hit) begin
						p_q   <= ptr_q;
						upd_q <= '{addr: addr_q, count: bumped, stamp: time_q};
						ptr_q <= '0;
						q_q   <= '0;
					end else begin
						if (take_least) begin
							least_q     <= ptr_q;
							least_cnt_q <= rd_entry.count;
						end
						if (last) begin
							// no match: evict the first slot with the least count
							p_q   <= take_least ? ptr_q : least_q;
							upd_q <= '{addr: addr_q, count: 32'd1, stamp: time_q};
							ptr_q <= '0;
							q_q   <= '0;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				ST_RANK: begin
					// count the slots that rank ahead of the updated entry
					if (ptr_q != p_q && (a_gt || (a_eq && ptr_q < p_q))) q_q <= q_q + 1'b1;
					if (!last) ptr_q <= ptr_q + 1'b1;
				end
				ST_MOVE: begin
					newest_q <= addr_q;
					ptr_q    <= q_q;
					rank_q   <= 3'(q_q);
					oor_q    <= 1'b0;
				end
				ST_OUT: ;
				default: ;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			entry_address        <= oor_q ? 8'd0  : rd_entry.addr;
			entry_count          <= oor_q ? 32'd0 : rd_entry.count;
			entry_last_seen      <= oor_q ? 48'd0 : rd_entry.stamp;
			entry_used           <= !oor_q && (rd_entry.count != 32'd0);
			entry_rank           <= rank_q;
			latest_error_address <= newest_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/tea_chk.sv
// Port-level assertion checker for the top error address table, with its bind.
`timescale 1ns / 1ps

module tea_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        mode,
	input logic [7:0]  address,
	input logic [2:0]  index,
	input logic [47:0] event_time,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  entry_address,
	input logic [31:0] entry_count,
	input logic [47:0] entry_last_seen,
	input logic        entry_used,
	input logic [2:0]  entry_rank,
	input logic [7:0]  latest_error_address
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({entry_address, entry_count,
			entry_last_seen, entry_used, entry_rank, latest_error_address}))
		else $error("result dropped or changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable({mode, address, index, event_time}))
		else $error("input transaction dropped or changed while waiting");

	a_used_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_used == (entry_count != 32'd0)))
		else $error("entry_used disagrees with entry_count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready again right after a transaction");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work in progress");

endmodule

bind top_error_address_table tea_chk u_tea_chk (.*);
